// ===== rtl/core/assert_macros.svh =====
// assertion macros for the loader rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define FLB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also holds during reset
`define FLB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FLB_ASSERT(lbl, clk, rst_n, prop, msg)
`define FLB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/flb_pkg.sv =====
// shared types and constants of the firmware block loader
`timescale 1ns / 1ps
`default_nettype none

package flb_pkg;

    // result kinds
    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_DONE    = 3'd1;
    localparam logic [2:0] KIND_BAD_HDR = 3'd2;
    localparam logic [2:0] KIND_OVERRUN = 3'd3;
    localparam logic [2:0] KIND_EMPTY   = 3'd4;

    // device register addresses
    localparam logic [11:0] ADDR_HEADER  = 12'h364;
    localparam logic [11:0] ADDR_ADDRESS = 12'h368;
    localparam logic [11:0] ADDR_DATA    = 12'h36c;

    // tag placed in the top byte of the header write
    localparam logic [7:0] HDR_TAG = 8'hc0;

    // one queue entry: a result, plus a trailing run done when extra is set
    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] reg_addr;
        logic [31:0] write_data;
        logic [16:0] end_pos;
        logic        extra;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/firmware_block_loader.sv =====
// top level of the firmware block loader
// a result is registered into the result queue and offered once the entries ahead of it are taken
// throughput: one input word per cycle while the result queue is not full; the final data
//   word of a run gives two results, a data write and then a run done
// input ready drops only while the two-entry result queue is full
// synchronous active-low reset: run idle, image length zero, queue empty
`timescale 1ns / 1ps
`default_nettype none

module firmware_block_loader #(
    parameter int MAX_IMAGE_WORDS = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [16:0] i_start_pos,
    input  wire logic [7:0]  i_block_limit,
    input  wire logic [31:0] i_image_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_kind,
    output logic [11:0]      o_reg_addr,
    output logic [31:0]      o_write_data,
    output logic [16:0]      o_end_pos,
    output logic             o_last
);

    logic             w_full;
    logic             w_take;
    logic             w_wr;
    flb_pkg::t_result w_ent;

    // input transfer
    assign o_ready = !w_full;
    assign w_take  = i_valid && o_ready;

    flb_parser #(
        .MAX_IMAGE_WORDS(MAX_IMAGE_WORDS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_take        (w_take),
        .i_cmd         (i_cmd),
        .i_start_pos   (i_start_pos),
        .i_block_limit (i_block_limit),
        .i_image_word  (i_image_word),
        .o_wr          (w_wr),
        .o_ent         (w_ent)
    );

    flb_out_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_wr),
        .i_ent        (w_ent),
        .o_full       (w_full),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_reg_addr   (o_reg_addr),
        .o_write_data (o_write_data),
        .o_end_pos    (o_end_pos),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/flb_parser.sv =====
// block parser: run state and per-word decode into result entries
`timescale 1ns / 1ps
`default_nettype none

module flb_parser #(
    parameter int MAX_IMAGE_WORDS = 65536
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [16:0]     i_cfg_data,
    input  wire logic            i_take,
    input  wire logic            i_cmd,
    input  wire logic [16:0]     i_start_pos,
    input  wire logic [7:0]      i_block_limit,
    input  wire logic [31:0]     i_image_word,
    output logic                 o_wr,
    output flb_pkg::t_result     o_ent
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_ADDRESS = 2'd2;
    localparam logic [1:0] PH_DATA    = 2'd3;

    // a MAX_IMAGE_WORDS above 17 bits of range never clamps
    localparam int CLAMP = (MAX_IMAGE_WORDS > 131071) ? 131071 : MAX_IMAGE_WORDS;
    localparam logic [16:0] CLAMP_W = 17'(CLAMP);

    logic [16:0] r_image_words;
    logic [1:0]  r_phase, n_phase;
    logic [16:0] r_pos, n_pos;
    logic [7:0]  r_wl, n_wl;
    logic [7:0]  r_bd, n_bd;
    logic [7:0]  r_limit, n_limit;

    logic [17:0] w_len;
    logic [7:0]  w_count;
    logic [16:0] w_pos_inc;

    // effective image length
    assign w_len = {1'b0, (r_image_words > CLAMP_W) ? CLAMP_W : r_image_words};
    assign w_count = i_image_word[7:0];
    assign w_pos_inc = r_pos + 17'd1;

    // next state and result for the item on the input
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_wl    = r_wl;
        n_bd    = r_bd;
        n_limit = r_limit;
        o_wr    = 1'b0;
        o_ent   = '0;
        if (i_take) begin
            if (!i_cmd) begin
                n_pos   = i_start_pos;
                n_limit = i_block_limit;
                n_bd    = 8'd0;
                n_wl    = 8'd0;
                if (w_len == 18'd0) begin
                    n_phase    = PH_IDLE;
                    o_wr       = 1'b1;
                    o_ent.kind = flb_pkg::KIND_EMPTY;
                end else if (!(({1'b0, i_start_pos} + 18'd3 <= w_len) &&
                               (i_block_limit != 8'd0))) begin
                    n_phase       = PH_IDLE;
                    o_wr          = 1'b1;
                    o_ent.kind    = flb_pkg::KIND_DONE;
                    o_ent.end_pos = i_start_pos;
                end else begin
                    n_phase = PH_HEADER;
                end
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        o_wr = 1'b1;
                        if (w_count == 8'd0 || i_image_word[31:8] != 24'd0) begin
                            n_phase    = PH_IDLE;
                            o_ent.kind = flb_pkg::KIND_BAD_HDR;
                        end else if ({1'b0, r_pos} + 18'd2 + {10'd0, w_count} > w_len) begin
                            n_phase    = PH_IDLE;
                            o_ent.kind = flb_pkg::KIND_OVERRUN;
                        end else begin
                            n_wl             = w_count;
                            n_pos            = w_pos_inc;
                            n_phase          = PH_ADDRESS;
                            o_ent.kind       = flb_pkg::KIND_WRITE;
                            o_ent.reg_addr   = flb_pkg::ADDR_HEADER;
                            o_ent.write_data = {flb_pkg::HDR_TAG, 16'd0, w_count - 8'd1};
                        end
                    end
                    PH_ADDRESS: begin
                        n_pos            = w_pos_inc;
                        n_phase          = PH_DATA;
                        o_wr             = 1'b1;
                        o_ent.kind       = flb_pkg::KIND_WRITE;
                        o_ent.reg_addr   = flb_pkg::ADDR_ADDRESS;
                        o_ent.write_data = i_image_word;
                    end
                    PH_DATA: begin
                        n_pos            = w_pos_inc;
                        n_wl             = r_wl - 8'd1;
                        o_wr             = 1'b1;
                        o_ent.kind       = flb_pkg::KIND_WRITE;
                        o_ent.reg_addr   = flb_pkg::ADDR_DATA;
                        o_ent.write_data = i_image_word;
                        if (n_wl == 8'd0) begin
                            n_bd = r_bd + 8'd1;
                            if (({1'b0, w_pos_inc} + 18'd3 <= w_len) && (n_bd < r_limit)) begin
                                n_phase = PH_HEADER;
                            end else begin
                                // last block: data write followed by run done
                                n_phase       = PH_IDLE;
                                o_ent.extra   = 1'b1;
                                o_ent.end_pos = w_pos_inc;
                            end
                        end
                    end
                    PH_IDLE: begin
                        // word with no run open is dropped
                        o_wr = 1'b0;
                    end
                endcase
            end
        end
    end

    // config register and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_words <= 17'd0;
            r_phase       <= PH_IDLE;
            r_pos         <= 17'd0;
            r_wl          <= 8'd0;
            r_bd          <= 8'd0;
            r_limit       <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_image_words <= i_cfg_data;
            end
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_wl    <= n_wl;
            r_bd    <= n_bd;
            r_limit <= n_limit;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/flb_out_queue.sv =====
// two-entry result queue that unpacks a trailing run done
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module flb_out_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire flb_pkg::t_result i_ent,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [2:0]            o_kind,
    output logic [11:0]           o_reg_addr,
    output logic [31:0]           o_write_data,
    output logic [16:0]           o_end_pos,
    output logic                  o_last
);

    flb_pkg::t_result r_ent [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             r_sub;

    flb_pkg::t_result w_head;
    logic             w_xfer;
    logic             w_pop;
    logic             w_first_half;

    assign w_head       = r_ent[r_rp];
    assign o_full       = (r_cnt == 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign w_xfer       = o_valid && i_ready;
    assign w_first_half = w_head.extra && !r_sub;
    assign w_pop        = w_xfer && !w_first_half;

    // output fields from the head entry
    always_comb begin
        if (r_sub) begin
            o_kind       = flb_pkg::KIND_DONE;
            o_reg_addr   = 12'd0;
            o_write_data = 32'd0;
            o_end_pos    = w_head.end_pos;
            o_last       = 1'b1;
        end else begin
            o_kind       = w_head.kind;
            o_reg_addr   = w_head.reg_addr;
            o_write_data = w_head.write_data;
            o_end_pos    = w_head.extra ? 17'd0 : w_head.end_pos;
            o_last       = !w_head.extra;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_ent[r_wp] <= i_ent;
        end
    end

    // pointers, fill count and second-half flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_sub <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp  <= !r_rp;
                r_sub <= 1'b0;
            end else if (w_xfer) begin
                r_sub <= 1'b1;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, w_pop};
        end
    end

    `FLB_ASSERT_ALWAYS(a_cnt_range, i_clk, !i_rst_n || r_cnt != 2'd3, "queue count out of range")
    `FLB_ASSERT(a_no_wr_full, i_clk, i_rst_n, i_wr |-> !o_full, "write into full queue")
    `FLB_ASSERT(a_sub_head, i_clk, i_rst_n, r_sub |-> (o_valid && w_head.extra),
                "second half without an extended head entry")
    `FLB_ASSERT(a_sub_after_first, i_clk, i_rst_n, $rose(r_sub) |-> $past(w_xfer),
                "second half started without a transfer")

endmodule

`default_nettype wire
